FILE: src/strc_pkg.sv
// Shared types and constants for the servo turnout ramp controller.
// No dependencies; every other file in src imports this package.
package strc_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Ticks to wait before stepping, and ticks to hold at the end angle
    localparam logic [2:0] SETTLE_TICKS = 3'd5;
    localparam logic [3:0] HOLD_TICKS   = 4'd10;

    localparam logic [7:0] STEP_RESET  = 8'd4;
    localparam logic       RELAY_RESET = 1'b1;

    // Command codes
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_PLUS   = 3'd1;
    localparam logic [2:0] FUNC_MINUS  = 3'd2;
    localparam logic [2:0] FUNC_STOP   = 3'd3;
    localparam logic [2:0] FUNC_PRESET = 3'd4;

    // Position codes
    localparam logic [1:0] POS_PLUS     = 2'd0;
    localparam logic [1:0] POS_MINUS    = 2'd1;
    localparam logic [1:0] POS_TO_PLUS  = 2'd2;
    localparam logic [1:0] POS_TO_MINUS = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PLUS_END  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS_END = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_LVL = 4'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] preset_angle;
        logic [1:0]  preset_position;
    } strc_cmd_t;

    typedef struct packed {
        logic [15:0] servo_angle;
        logic        servo_on;
        logic        relay_level;
        logic        relay_written;
        logic [1:0]  position_code;
        logic        busy_res;
        logic        done_pulse;
        logic        plus_move_event;
        logic        minus_move_event;
    } strc_res_t;

    typedef struct packed {
        logic [15:0] plus_end_angle;
        logic [15:0] minus_end_angle;
        logic [7:0]  step_per_tick;
        logic        relay_level_for_plus;
    } strc_cfg_t;

    typedef struct packed {
        logic [15:0] angle_now;
        logic [1:0]  position_now;
        logic        active;
        logic        target_is_minus;
        logic [2:0]  settle_count;
        logic [3:0]  hold_count;
        logic        relay_flipped;
        logic [15:0] mid_angle;
        logic        relay_out;
        logic        pulses_on;
    } strc_state_t;

endpackage

FILE: src/servo_turnout_ramp_controller_unit.sv
// Top level of the servo turnout ramp controller: input register, sequencer
// state, result register. Depends on strc_pkg, strc_cfg_regs and strc_step.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   cmd      | in        | cmd_valid / cmd_stall  | strc_cmd_t (func, preset)
//   res      | out       | res_valid / res_stall  | strc_res_t (angle, flags)
//   cfg      | in        | cfg_wr_en, no wait     | cfg_index, cfg_wdata
//
// One item per clock sustained while res_stall is low. An accepted item sits
// in the input register, passes through the step logic into the result
// register and the sequencer state, and is offered as a result from then on.
// Reset is asynchronous and active low; it clears the valid bits, the state
// and loads the configuration registers with their reset values.
// A held result stalls the step stage; the input register still takes one
// more item, and cmd_stall rises only when both stages are full.
module servo_turnout_ramp_controller_unit
    import strc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  strc_cmd_t             cmd,
    output logic                  res_valid,
    input  logic                  res_stall,
    output strc_res_t             res,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    strc_cfg_t   cfg;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    strc_cmd_t   s1_item_reg;

    strc_state_t state_reg;
    strc_state_t state_next;

    logic        res_valid_reg;
    logic        res_valid_next;
    strc_res_t   res_reg;
    strc_res_t   res_next;

    logic        advance;
    logic        cmd_take;

    strc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    strc_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .cmd        (s1_item_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // Advance the step stage whenever the result register is free or drains
    assign advance   = !res_valid_reg || !res_stall;
    // Stall input only when the input register holds an item that cannot move
    assign cmd_stall = s1_valid_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    assign s1_valid_next  = cmd_stall ? s1_valid_reg : cmd_valid;
    assign res_valid_next = advance ? s1_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            // Commit the sequencer state only when the item moves to the result
            if (advance && s1_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: hold the item until it moves on
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_item_reg <= cmd;
        end
        if (advance && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A stalled item in the input register is never dropped
    a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("input item dropped while step stage stalled");

    // Servo pulses run exactly while a sequence is active
    a_pulses_active: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pulses_on == state_reg.active)
        else $error("servo pulses and active flag disagree");

    // Settle counter never runs past its limit
    a_settle_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.settle_count <= SETTLE_TICKS)
        else $error("settle counter out of range");

    // A done pulse always leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.done_pulse) |-> !res_reg.busy_res)
        else $error("done pulse with sequence still active");

    // A move event always reports the matching moving position
    a_move_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.plus_move_event) |->
        (res_reg.position_code == POS_TO_PLUS && !res_reg.minus_move_event))
        else $error("plus move event without moving-to-plus position");

endmodule

FILE: src/strc_cfg_regs.sv
// Configuration register file: end angles, step size, relay polarity.
// Depends on strc_pkg.
module strc_cfg_regs
    import strc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output strc_cfg_t             cfg
);

    strc_cfg_t cfg_reg;
    strc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PLUS_END:  cfg_next.plus_end_angle       = cfg_wdata;
                CFG_MINUS_END: cfg_next.minus_end_angle      = cfg_wdata;
                CFG_STEP:      cfg_next.step_per_tick        = cfg_wdata[7:0];
                CFG_RELAY_LVL: cfg_next.relay_level_for_plus = cfg_wdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plus_end_angle       <= '0;
            cfg_reg.minus_end_angle      <= '0;
            cfg_reg.step_per_tick        <= STEP_RESET;
            cfg_reg.relay_level_for_plus <= RELAY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/strc_step.sv
// Next-state and result logic for one item of the turnout sequencer.
// Depends on strc_pkg; purely combinational.
module strc_step
    import strc_pkg::*;
(
    input  strc_state_t state,
    input  strc_cfg_t   cfg,
    input  strc_cmd_t   cmd,
    output strc_state_t state_next,
    output strc_res_t   res
);

    logic [15:0] lo_angle;
    logic [15:0] hi_angle;
    logic [15:0] span;
    logic [15:0] mid_new;
    logic [15:0] end_angle;
    logic        up_dir;
    logic [16:0] up_sum;
    logic [15:0] up_val;
    logic [15:0] dn_floor;
    logic [15:0] dn_val;
    logic [15:0] angle_stepped;
    logic        crossed;
    logic [3:0]  hold_inc;
    logic        wrote;
    logic        done;
    logic        ev_plus;
    logic        ev_minus;

    // Midpoint of the two end angles, fixed when a move starts
    assign lo_angle = (cfg.plus_end_angle < cfg.minus_end_angle) ?
                      cfg.plus_end_angle : cfg.minus_end_angle;
    assign hi_angle = (cfg.plus_end_angle < cfg.minus_end_angle) ?
                      cfg.minus_end_angle : cfg.plus_end_angle;
    assign span     = hi_angle - lo_angle;
    assign mid_new  = lo_angle + {1'b0, span[15:1]};

    assign end_angle = state.target_is_minus ? cfg.minus_end_angle : cfg.plus_end_angle;
    assign up_dir    = (!state.target_is_minus) !=
                       (cfg.plus_end_angle < cfg.minus_end_angle);

    // Count up without wrap, clamp at the end angle
    assign up_sum = {1'b0, state.angle_now} + {9'b0, cfg.step_per_tick};
    assign up_val = (up_sum > {1'b0, end_angle}) ? end_angle : up_sum[15:0];

    // Count down floored at zero, then raised to the end angle
    assign dn_floor = (state.angle_now >= {8'b0, cfg.step_per_tick}) ?
                      (state.angle_now - {8'b0, cfg.step_per_tick}) : 16'd0;
    assign dn_val   = (dn_floor < end_angle) ? end_angle : dn_floor;

    assign angle_stepped = up_dir ? up_val : dn_val;
    assign crossed       = up_dir ? (angle_stepped > state.mid_angle) :
                                    (angle_stepped < state.mid_angle);
    assign hold_inc      = state.hold_count + 4'd1;

    always_comb
    begin
        state_next = state;
        wrote      = 1'b0;
        done       = 1'b0;
        ev_plus    = 1'b0;
        ev_minus   = 1'b0;

        unique case (cmd.func)
            FUNC_TICK:
            begin
                if (state.active)
                begin
                    if (state.settle_count < SETTLE_TICKS)
                    begin
                        state_next.settle_count = state.settle_count + 3'd1;
                    end
                    else if (state.angle_now == end_angle)
                    begin
                        state_next.hold_count = hold_inc;
                        if (hold_inc >= HOLD_TICKS)
                        begin
                            state_next.position_now = state.target_is_minus ?
                                                      POS_MINUS : POS_PLUS;
                            state_next.active    = 1'b0;
                            state_next.pulses_on = 1'b0;
                            done                 = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next.angle_now = angle_stepped;
                        if (!state.relay_flipped && crossed)
                        begin
                            state_next.relay_flipped = 1'b1;
                            state_next.relay_out     =
                                (state.position_now == POS_TO_PLUS) ==
                                cfg.relay_level_for_plus;
                            wrote = 1'b1;
                        end
                    end
                end
            end
            FUNC_PLUS, FUNC_MINUS:
            begin
                if ((cmd.func == FUNC_PLUS &&
                     state.position_now != POS_PLUS &&
                     state.position_now != POS_TO_PLUS) ||
                    (cmd.func == FUNC_MINUS &&
                     state.position_now != POS_MINUS &&
                     state.position_now != POS_TO_MINUS))
                begin
                    state_next.active          = 1'b1;
                    state_next.target_is_minus = (cmd.func == FUNC_MINUS);
                    state_next.settle_count    = '0;
                    state_next.hold_count      = '0;
                    state_next.relay_flipped   = 1'b0;
                    state_next.mid_angle       = mid_new;
                    state_next.position_now    = (cmd.func == FUNC_MINUS) ?
                                                 POS_TO_MINUS : POS_TO_PLUS;
                    state_next.pulses_on       = 1'b1;
                    ev_plus                    = (cmd.func == FUNC_PLUS);
                    ev_minus                   = (cmd.func == FUNC_MINUS);
                end
            end
            FUNC_STOP:
            begin
                if (state.active)
                begin
                    state_next.active    = 1'b0;
                    state_next.pulses_on = 1'b0;
                    done                 = 1'b1;
                end
            end
            FUNC_PRESET:
            begin
                state_next.angle_now    = cmd.preset_angle;
                state_next.position_now = cmd.preset_position;
            end
            default:
            begin
                state_next = state;
            end
        endcase

        res.servo_angle      = state_next.angle_now;
        res.servo_on         = state_next.pulses_on;
        res.relay_level      = state_next.relay_out;
        res.relay_written    = wrote;
        res.position_code    = state_next.position_now;
        res.busy_res         = state_next.active;
        res.done_pulse       = done;
        res.plus_move_event  = ev_plus;
        res.minus_move_event = ev_minus;
    end

endmodule
